@@ hdl/erd_pkg.sv @@
// shared types and constants for the event record deframer
`timescale 1ns / 1ps
`default_nettype none

package erd_pkg;

  // record kind bytes and header rules
  localparam logic [7:0] REC_TEXT = 8'h63;  // 'c'
  localparam logic [7:0] REC_ADD  = 8'h41;  // 'A'
  localparam int unsigned MIN_LEN = 2;

  // result queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // result kinds
  typedef enum logic [2:0] {
    KIND_TEXT_BYTE = 3'd0,
    KIND_TEXT_END  = 3'd1,
    KIND_ADD_OBJ   = 3'd2,
    KIND_UNKNOWN   = 3'd3,
    KIND_BAD       = 3'd4
  } kind_t;

  // one result item as it travels through the queue
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  source_id;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [7:0]  text_byte;
    logic        record_end;
  } result_t;

  // push side of the queue
  typedef struct packed {
    logic    push;
    result_t entry;
  } push_t;

endpackage

`default_nettype wire

@@ hdl/event_record_deframer.sv @@
// top level of the event record deframer
`timescale 1ns / 1ps
`default_nettype none

// Splits a byte stream into records (source byte, 16-bit big-endian length,
// payload) and reports text bytes, text record ends, add object records,
// unknown kinds and bad lengths. One byte is taken per cycle while the queue
// is not full: the parser updates its state and pushes at most one result into a
// four-entry queue, whose head drives the output stream. Input ready drops
// only while that queue is full, so bytes flow at one per cycle for as long
// as the output side takes results; each result is written into the queue
// before it appears on the output. No reset sweep is needed.

module event_record_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [7:0] source_id, [23:8] x_coord,
                                      // [39:24] y_coord, [47:40] text_byte
  output logic [2:0]       m_tuser,   // [2:0] kind
  output logic             m_tlast    // record_end
);

  erd_pkg::push_t   push;
  erd_pkg::result_t head;
  logic             queue_full;

  // front: parse and classify
  erd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .queue_full (queue_full),
    .to_queue   (push)
  );

  // back: result queue feeding the output stream
  erd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .from_front (push),
    .full       (queue_full),
    .head_valid (m_tvalid),
    .head       (head),
    .pop        (m_tready)
  );

  // output packing
  assign m_tdata = {head.text_byte, head.y_coord, head.x_coord, head.source_id};
  assign m_tuser = head.kind;
  assign m_tlast = head.record_end;

endmodule

`default_nettype wire

@@ hdl/erd_front.sv @@
// record parser: accepts bytes, tracks the record and classifies results
`timescale 1ns / 1ps
`default_nettype none

module erd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,
  input  wire logic             queue_full,
  output erd_pkg::push_t        to_queue
);

  typedef enum logic [1:0] {
    PH_SRC     = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_LEN_LO  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  source_reg, source_reg_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [2:0]  payload_pos, payload_pos_next;
  logic [7:0]  record_kind, record_kind_next;
  logic [7:0]  text_left, text_left_next;
  logic [15:0] x_hold, x_hold_next;
  logic [7:0]  y_high, y_high_next;

  logic             accept;
  logic             last;
  logic             res_valid;
  logic [15:0]      full_len;
  erd_pkg::result_t res;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign last     = bytes_left < 16'(erd_pkg::MIN_LEN);
  assign full_len = {bytes_left[15:8], s_tdata};

  // next state and result for the byte on the input
  always_comb begin
    phase_next       = phase;
    source_reg_next  = source_reg;
    bytes_left_next  = bytes_left;
    payload_pos_next = payload_pos;
    record_kind_next = record_kind;
    text_left_next   = text_left;
    x_hold_next      = x_hold;
    y_high_next      = y_high;
    res_valid        = 1'b0;
    res.kind         = erd_pkg::KIND_BAD;
    res.source_id    = source_reg;
    res.x_coord      = '0;
    res.y_coord      = '0;
    res.text_byte    = '0;
    res.record_end   = 1'b1;

    unique case (phase)
      PH_SRC: begin
        source_reg_next = s_tdata;
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        bytes_left_next = {s_tdata, 8'h00};
        phase_next      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        bytes_left_next  = full_len;
        payload_pos_next = '0;
        record_kind_next = '0;
        text_left_next   = '0;
        x_hold_next      = '0;
        y_high_next      = '0;
        if (full_len == '0) begin
          // empty record is bad
          res_valid  = 1'b1;
          phase_next = PH_SRC;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (payload_pos == '0) begin
          // kind byte
          record_kind_next = s_tdata;
          res_valid        = last;
        end else if (record_kind == erd_pkg::REC_TEXT) begin
          if (payload_pos == 3'd1) begin
            text_left_next = s_tdata;
            res_valid      = last;
            res.kind       = erd_pkg::KIND_TEXT_END;
          end else if (text_left != '0) begin
            text_left_next = text_left - 8'd1;
            res_valid      = 1'b1;
            res.kind       = erd_pkg::KIND_TEXT_BYTE;
            res.text_byte  = s_tdata;
            res.record_end = last;
          end else begin
            res_valid = last;
            res.kind  = erd_pkg::KIND_TEXT_END;
          end
        end else if (record_kind == erd_pkg::REC_ADD) begin
          // collect coordinates, the y low byte lands in text_left
          unique case (payload_pos)
            3'd1:    x_hold_next    = {s_tdata, 8'h00};
            3'd2:    x_hold_next    = {x_hold[15:8], s_tdata};
            3'd3:    y_high_next    = s_tdata;
            3'd4:    text_left_next = s_tdata;
            default: ;
          endcase
          res_valid = last;
          if (payload_pos >= 3'd4) begin
            res.kind    = erd_pkg::KIND_ADD_OBJ;
            res.x_coord = x_hold;
            res.y_coord = (payload_pos == 3'd4) ? {y_high, s_tdata} : {y_high, text_left};
          end
        end else begin
          res_valid = last;
          res.kind  = erd_pkg::KIND_UNKNOWN;
        end

        if (payload_pos != 3'd7) begin
          payload_pos_next = payload_pos + 3'd1;
        end
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - 16'd1;
        end
        if (last) begin
          phase_next = PH_SRC;
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SRC;
      source_reg  <= '0;
      bytes_left  <= '0;
      payload_pos <= '0;
      record_kind <= '0;
      text_left   <= '0;
      x_hold      <= '0;
      y_high      <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      source_reg  <= source_reg_next;
      bytes_left  <= bytes_left_next;
      payload_pos <= payload_pos_next;
      record_kind <= record_kind_next;
      text_left   <= text_left_next;
      x_hold      <= x_hold_next;
      y_high      <= y_high_next;
    end
  end

  assign to_queue.push  = accept && res_valid;
  assign to_queue.entry = res;

  // a closing result sends the parser back to the header
  a_end_to_src: assert property (@(posedge clk) disable iff (rst)
    (to_queue.push && to_queue.entry.record_end) |=> (phase == PH_SRC))
    else $error("record end did not return to source phase");

  // only text bytes may leave a record open
  a_open_only_text: assert property (@(posedge clk) disable iff (rst)
    (to_queue.push && !to_queue.entry.record_end) |->
      (to_queue.entry.kind == erd_pkg::KIND_TEXT_BYTE))
    else $error("non-text result left record open");

  // a source byte is always followed by the length high byte
  a_src_to_len: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_SRC) |=> (phase == PH_LEN_HI))
    else $error("source byte not followed by length phase");

endmodule

`default_nettype wire

@@ hdl/erd_queue.sv @@
// short result queue between the parser and the output stream
`timescale 1ns / 1ps
`default_nettype none

module erd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  erd_pkg::push_t        from_front,
  output logic                  full,
  output logic                  head_valid,
  output erd_pkg::result_t      head,
  input  wire logic             pop
);

  erd_pkg::result_t              mem [erd_pkg::QUEUE_DEPTH];
  logic [erd_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [erd_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [erd_pkg::QUEUE_CW-1:0]  count;
  logic                          do_pop;

  assign full       = count == erd_pkg::QUEUE_CW'(erd_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (from_front.push) begin
      mem[wr_ptr] <= from_front.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (from_front.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (from_front.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !from_front.push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    from_front.push |-> !full)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= erd_pkg::QUEUE_CW'(erd_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !from_front.push) |=> (count == $past(count) - 1'b1))
    else $error("pop did not lower count");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the event record deframer
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned TAIL_CYCLES = 10;

  // parser phase of the predicted state
  typedef enum logic [1:0] {
    PH_SRC     = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_LEN_LO  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  event_record_deframer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // predicted parser state
  phase_t      p_phase = PH_SRC;
  logic [7:0]  p_source = 8'h00;
  logic [15:0] p_left = 16'h0000;
  logic [2:0]  p_pos = 3'd0;
  logic [7:0]  p_rec_kind = 8'h00;
  logic [7:0]  p_text_left = 8'h00;
  logic [15:0] p_x_hold = 16'h0000;
  logic [7:0]  p_y_high = 8'h00;

  erd_pkg::result_t pending_results[$];
  logic [7:0]       body_q[$];

  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned kind_seen[5];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_len = 0;
  bit          sender_idle_on = 1'b1;
  bit          receiver_idle_on = 1'b1;

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // work out what one accepted byte causes
  task automatic deframe_byte(input logic [7:0] b);
    erd_pkg::result_t r;
    logic             emit;
    logic             last;
    r = '0;
    emit = 1'b0;
    last = 1'b0;
    case (p_phase)
      PH_SRC: begin
        p_source = b;
        p_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        p_left = {b, 8'h00};
        p_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        p_left = {p_left[15:8], b};
        p_pos = 3'd0;
        p_rec_kind = 8'h00;
        p_text_left = 8'h00;
        p_x_hold = 16'h0000;
        p_y_high = 8'h00;
        if (p_left == 16'h0000) begin
          emit = 1'b1;
          r.kind = erd_pkg::KIND_BAD;
          r.record_end = 1'b1;
          p_phase = PH_SRC;
        end else begin
          p_phase = PH_PAYLOAD;
        end
      end
      default: begin
        last = (p_left <= 16'd1);
        if (p_pos == 3'd0) begin
          p_rec_kind = b;
          if (last) begin
            emit = 1'b1;
            r.kind = erd_pkg::KIND_BAD;
          end
        end else if (p_rec_kind == erd_pkg::REC_TEXT) begin
          if (p_pos == 3'd1) begin
            p_text_left = b;
            if (last) begin
              emit = 1'b1;
              r.kind = erd_pkg::KIND_TEXT_END;
            end
          end else if (p_text_left != 8'h00) begin
            p_text_left = p_text_left - 8'd1;
            emit = 1'b1;
            r.kind = erd_pkg::KIND_TEXT_BYTE;
            r.text_byte = b;
          end else if (last) begin
            emit = 1'b1;
            r.kind = erd_pkg::KIND_TEXT_END;
          end
        end else if (p_rec_kind == erd_pkg::REC_ADD) begin
          case (p_pos)
            3'd1: p_x_hold = {b, 8'h00};
            3'd2: p_x_hold = {p_x_hold[15:8], b};
            3'd3: p_y_high = b;
            3'd4: p_text_left = b;
            default: ;
          endcase
          if (last) begin
            emit = 1'b1;
            if (p_pos >= 3'd4) begin
              r.kind = erd_pkg::KIND_ADD_OBJ;
              r.x_coord = p_x_hold;
              r.y_coord = {p_y_high, p_text_left};
            end else begin
              r.kind = erd_pkg::KIND_BAD;
            end
          end
        end else if (last) begin
          emit = 1'b1;
          r.kind = erd_pkg::KIND_UNKNOWN;
        end
        r.record_end = last;
        if (p_pos < 3'd7) p_pos = p_pos + 3'd1;
        if (p_left != 16'h0000) p_left = p_left - 16'd1;
        if (last) p_phase = PH_SRC;
      end
    endcase
    r.source_id = p_source;
    if (emit) pending_results.push_back(r);
  endtask

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    erd_pkg::result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (m_tuser < 3'd5) kind_seen[m_tuser] <= kind_seen[m_tuser] + 1;
      if (pending_results.size() == 0) begin
        mismatches <= mismatches + 1;
        $display("%0t: unexpected result kind %0d src %02h x %04h y %04h ch %02h end %0b",
                 $time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[39:24],
                 m_tdata[47:40], m_tlast);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tuser != exp_r.kind || m_tdata[7:0] != exp_r.source_id ||
            m_tdata[23:8] != exp_r.x_coord || m_tdata[39:24] != exp_r.y_coord ||
            m_tdata[47:40] != exp_r.text_byte || m_tlast != exp_r.record_end) begin
          mismatches <= mismatches + 1;
          $display("%0t: mismatch expected kind %0d src %02h x %04h y %04h ch %02h end %0b",
                   $time, exp_r.kind, exp_r.source_id, exp_r.x_coord, exp_r.y_coord,
                   exp_r.text_byte, exp_r.record_end);
          $display("%0t:          actual   kind %0d src %02h x %04h y %04h ch %02h end %0b",
                   $time, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[39:24],
                   m_tdata[47:40], m_tlast);
        end
      end
    end
  end

  // output side: random stalls per result, plus an occasional long hold-off
  initial begin
    int unsigned wait_n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        wait_n = hold_len;
        hold_len = 0;
      end else begin
        wait_n = receiver_idle_on ? $urandom_range(0, 8) : 0;
      end
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // offer one byte after a random gap and wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = sender_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // header then the bytes held in body_q
  task automatic send_record(input logic [7:0] src, input logic [15:0] len);
    int i;
    send_byte(src);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (i = 0; i < body_q.size(); i++) send_byte(body_q[i]);
  endtask

  // stop offering and wait until every predicted result has come
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic fill_random(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) body_q.push_back(8'($urandom));
  endtask

  // one record of a random kind with random content, well-formed or not
  task automatic send_random_record();
    int unsigned sel;
    int unsigned len;
    logic [7:0]  k;
    body_q = {};
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: begin
        len = $urandom_range(2, 14);
        body_q.push_back(erd_pkg::REC_TEXT);
        body_q.push_back(8'($urandom_range(0, 12)));
        fill_random(len - 2);
      end
      4, 5: begin
        len = $urandom_range(2, 9);
        body_q.push_back(erd_pkg::REC_ADD);
        fill_random(len - 1);
      end
      6, 7: begin
        len = $urandom_range(1, 8);
        k = 8'($urandom);
        body_q.push_back(k);
        fill_random(len - 1);
      end
      8: begin
        len = $urandom_range(0, 1);
        fill_random(len);
      end
      default: begin
        len = $urandom_range(12, 40);
        body_q.push_back(erd_pkg::REC_TEXT);
        body_q.push_back(8'($urandom));
        fill_random(len - 2);
      end
    endcase
    send_record(8'($urandom), 16'(len));
  endtask

  // edge lengths, each record kind, text cut and short add records
  task automatic test_directed();
    int i;
    body_q = {};
    send_record(8'h00, 16'd0);
    body_q = {erd_pkg::REC_ADD};
    send_record(8'hFF, 16'd1);
    body_q = {erd_pkg::REC_TEXT, 8'd3, 8'h68, 8'h69, 8'h21};
    send_record(8'h12, 16'd5);
    // text longer than the payload is cut
    body_q = {erd_pkg::REC_TEXT, 8'hFF, 8'h00, 8'hFF};
    send_record(8'h34, 16'd4);
    body_q = {erd_pkg::REC_TEXT, 8'd1, 8'h78, 8'h00, 8'h00, 8'h00};
    send_record(8'h56, 16'd6);
    body_q = {erd_pkg::REC_TEXT, 8'd0, 8'h55};
    send_record(8'h01, 16'd3);
    body_q = {erd_pkg::REC_TEXT, 8'd9};
    send_record(8'h02, 16'd2);
    body_q = {erd_pkg::REC_ADD, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_record(8'h80, 16'd5);
    // add object with bytes past the coordinates
    body_q = {erd_pkg::REC_ADD, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hAA, 8'h55, 8'h41, 8'h63,
              8'hFF};
    send_record(8'h7F, 16'd10);
    // short add object records
    body_q = {erd_pkg::REC_ADD, 8'h12};
    send_record(8'h03, 16'd2);
    body_q = {erd_pkg::REC_ADD, 8'h12, 8'h34};
    send_record(8'h04, 16'd3);
    body_q = {erd_pkg::REC_ADD, 8'h12, 8'h34, 8'h56};
    send_record(8'h05, 16'd4);
    body_q = {8'hFF, 8'h00, 8'h63};
    send_record(8'h06, 16'd3);
    body_q = {8'h00};
    send_record(8'h07, 16'd1);
    // long payload with the largest text length
    body_q = {erd_pkg::REC_TEXT, 8'd255};
    for (i = 0; i < 256; i++) body_q.push_back(8'(i));
    send_record(8'hA5, 16'h0102);
    drain();
  endtask

  // mostly well-formed records, random content and sizes
  task automatic test_random_records();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) send_random_record();
    drain();
  endtask

  // receiver stalls long while the sender keeps going, so input backs up
  task automatic test_backpressure();
    sender_idle_on = 1'b0;
    hold_len = 80;
    body_q = {erd_pkg::REC_TEXT, 8'd60};
    fill_random(60);
    send_record(8'h99, 16'd62);
    drain();
    sender_idle_on = 1'b1;
  endtask

  // back-to-back items with both sides always ready
  task automatic test_full_rate();
    int unsigned start;
    sender_idle_on = 1'b0;
    receiver_idle_on = 1'b0;
    start = bytes_sent;
    while (bytes_sent - start < 120) send_random_record();
    drain();
    sender_idle_on = 1'b1;
    receiver_idle_on = 1'b1;
  endtask

  // reset, tests in turn, verdict
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_records();
    test_backpressure();
    test_full_rate();
    $display("covered %0d bytes, %0d results: text %0d, text end %0d, add %0d,",
             bytes_sent, results_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("unknown %0d, bad length %0d; with long output stall and full-rate run",
             kind_seen[3], kind_seen[4]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
